>>> design/pfdec_pkg.sv
// Package for the Playfair decryption unit: shared constants, the queued
// command type and small helpers for places in the 5x5 square.
// No dependencies.
`default_nettype none

package pfdec_pkg;

  localparam int unsigned LetterW    = 5;
  localparam int unsigned RcW        = 3;
  localparam int unsigned SqSide     = 5;
  localparam int unsigned SqSize     = 25;
  localparam int unsigned NumLetters = 26;

  localparam logic [LetterW-1:0] LetterI   = 5'd8;
  localparam logic [LetterW-1:0] LetterJ   = 5'd9;
  localparam logic [LetterW-1:0] LastLetter = 5'd25;
  localparam logic [LetterW-1:0] LetterLimit = 5'd26;
  localparam logic [RcW-1:0]     LastRc    = 3'd4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_END   = 2'd2,
    OP_PAIR  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
  } cmd_t;

  function automatic logic [LetterW-1:0] fold_letter(input logic [LetterW-1:0] v);
    return (v == LetterJ) ? LetterI : v;
  endfunction

  function automatic logic [RcW-1:0] place_row(input logic [LetterW-1:0] p);
    logic [RcW-1:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic logic [LetterW-1:0] make_place(input logic [RcW-1:0] r,
                                                    input logic [RcW-1:0] c);
    logic [LetterW-1:0] rw;
    rw = {2'b00, r};
    return (rw << 2) + rw + {2'b00, c};
  endfunction

  function automatic logic [RcW-1:0] place_col(input logic [LetterW-1:0] p);
    logic [LetterW-1:0] base;
    logic [LetterW-1:0] diff;
    base = make_place(place_row(p), 3'd0);
    diff = p - base;
    return diff[RcW-1:0];
  endfunction

  function automatic logic [RcW-1:0] wrap_dec(input logic [RcW-1:0] v);
    return (v == 3'd0) ? LastRc : v - 3'd1;
  endfunction

endpackage

`default_nettype wire

>>> design/pfdec_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module pfdec_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 25
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_a_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_b_i,
  output logic      [Width-1:0]         rd_data_a_o,
  output logic      [Width-1:0]         rd_data_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

`default_nettype wire

>>> design/pfdec_front.sv
// Front end of the Playfair decryption unit: folds j to i, checks ranges and
// drops requests that can never give a result. Uses pfdec_pkg.
`default_nettype none

module pfdec_front (
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   action_i,
  input  wire logic [pfdec_pkg::LetterW-1:0] letter_first_i,
  input  wire logic [pfdec_pkg::LetterW-1:0] letter_second_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output pfdec_pkg::cmd_t                   q_cmd_o
);

  logic                          first_ok;
  logic                          second_ok;
  logic [pfdec_pkg::LetterW-1:0] first_f;
  logic [pfdec_pkg::LetterW-1:0] second_f;
  pfdec_pkg::op_e                op;
  logic                          keep;

  assign first_ok  = letter_first_i < pfdec_pkg::LetterLimit;
  assign second_ok = letter_second_i < pfdec_pkg::LetterLimit;
  assign first_f   = pfdec_pkg::fold_letter(letter_first_i);
  assign second_f  = pfdec_pkg::fold_letter(letter_second_i);
  assign op        = pfdec_pkg::op_e'(action_i);

  always_comb begin
    unique case (op)
      pfdec_pkg::OP_CLEAR: keep = 1'b1;
      pfdec_pkg::OP_KEY:   keep = first_ok;
      pfdec_pkg::OP_END:   keep = 1'b1;
      pfdec_pkg::OP_PAIR:  keep = first_ok && second_ok && (first_f != second_f);
      default:             keep = 1'b0;
    endcase
  end

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i && keep;
  assign q_cmd_o.op     = op;
  assign q_cmd_o.first  = first_f;
  assign q_cmd_o.second = second_f;

endmodule

`default_nettype wire

>>> design/pfdec_queue.sv
// Short command queue between the front end and the back end.
// Uses pfdec_pkg.
`default_nettype none

module pfdec_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire pfdec_pkg::cmd_t cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 head_valid_o,
  output pfdec_pkg::cmd_t      head_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  pfdec_pkg::cmd_t   buf_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o       = count_q == CountW'(Depth);
  assign head_valid_o = count_q != '0;
  assign head_o       = buf_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CountW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> design/pfdec_back.sv
// Back end of the Playfair decryption unit: builds the key square, fills it
// at end of key and decrypts pairs. Uses pfdec_pkg and pfdec_ram.
`default_nettype none

module pfdec_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          head_valid_i,
  input  wire pfdec_pkg::cmd_t               head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pfdec_pkg::LetterW-1:0]      plain_first_o,
  output logic [pfdec_pkg::LetterW-1:0]      plain_second_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FILL   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_READ   = 4'b1000
  } state_e;

  state_e                              state_q, state_d;
  logic [pfdec_pkg::NumLetters-1:0]    used_q, used_d;
  logic [pfdec_pkg::LetterW-1:0]       filled_q, filled_d;
  logic                                ready_q, ready_d;
  logic [pfdec_pkg::LetterW-1:0]       fill_q, fill_d;
  logic [pfdec_pkg::LetterW-1:0]       sq_addr_a_q, sq_addr_a_d;
  logic [pfdec_pkg::LetterW-1:0]       sq_addr_b_q, sq_addr_b_d;
  logic                                out_valid_q, out_valid_d;
  logic [pfdec_pkg::LetterW-1:0]       plain_first_q;
  logic [pfdec_pkg::LetterW-1:0]       plain_second_q;
  logic                                out_load;

  logic                                wr_en;
  logic [pfdec_pkg::LetterW-1:0]       wr_letter;
  logic [pfdec_pkg::LetterW-1:0]       place_a, place_b;
  logic [pfdec_pkg::LetterW-1:0]       sq_data_a, sq_data_b;
  logic [pfdec_pkg::LetterW-1:0]       sq_rd_a, sq_rd_b;

  logic [pfdec_pkg::RcW-1:0]           ra, ca, rb, cb;
  logic [pfdec_pkg::LetterW-1:0]       oa, ob;

  always_comb begin
    ra = pfdec_pkg::place_row(place_a);
    ca = pfdec_pkg::place_col(place_a);
    rb = pfdec_pkg::place_row(place_b);
    cb = pfdec_pkg::place_col(place_b);
    if (ra == rb) begin
      oa = pfdec_pkg::make_place(ra, pfdec_pkg::wrap_dec(ca));
      ob = pfdec_pkg::make_place(rb, pfdec_pkg::wrap_dec(cb));
    end else if (ca == cb) begin
      oa = pfdec_pkg::make_place(pfdec_pkg::wrap_dec(ra), ca);
      ob = pfdec_pkg::make_place(pfdec_pkg::wrap_dec(rb), cb);
    end else begin
      oa = pfdec_pkg::make_place(ra, cb);
      ob = pfdec_pkg::make_place(rb, ca);
    end
  end

  assign out_load = (state_q == ST_READ) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    filled_d    = filled_q;
    ready_d     = ready_q;
    fill_d      = fill_q;
    sq_addr_a_d = sq_addr_a_q;
    sq_addr_b_d = sq_addr_b_q;
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    wr_letter   = head_i.first;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          unique case (head_i.op)
            pfdec_pkg::OP_CLEAR: begin
              used_d   = '0;
              filled_d = '0;
              ready_d  = 1'b0;
            end
            pfdec_pkg::OP_KEY: begin
              if (!ready_q && !used_q[head_i.first] &&
                  filled_q < pfdec_pkg::LetterW'(pfdec_pkg::SqSize)) begin
                wr_en                = 1'b1;
                used_d[head_i.first] = 1'b1;
                filled_d             = filled_q + 5'd1;
              end
            end
            pfdec_pkg::OP_END: begin
              if (!ready_q) begin
                fill_d  = '0;
                state_d = ST_FILL;
              end
            end
            pfdec_pkg::OP_PAIR: begin
              if (ready_q) begin
                state_d = ST_LOOKUP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        wr_letter = fill_q;
        if (fill_q != pfdec_pkg::LetterJ && !used_q[fill_q] &&
            filled_q < pfdec_pkg::LetterW'(pfdec_pkg::SqSize)) begin
          wr_en          = 1'b1;
          used_d[fill_q] = 1'b1;
          filled_d       = filled_q + 5'd1;
        end
        fill_d = fill_q + 5'd1;
        if (fill_q == pfdec_pkg::LastLetter) begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        sq_addr_a_d = oa;
        sq_addr_b_d = ob;
        state_d     = ST_READ;
      end
      ST_READ: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign sq_rd_a = (state_q == ST_LOOKUP) ? oa : sq_addr_a_q;
  assign sq_rd_b = (state_q == ST_LOOKUP) ? ob : sq_addr_b_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  pfdec_ram #(
    .Width(pfdec_pkg::LetterW),
    .Depth(pfdec_pkg::NumLetters)
  ) u_place_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_letter),
    .wr_data_i  (filled_q),
    .rd_addr_a_i(head_i.first),
    .rd_addr_b_i(head_i.second),
    .rd_data_a_o(place_a),
    .rd_data_b_o(place_b)
  );

  pfdec_ram #(
    .Width(pfdec_pkg::LetterW),
    .Depth(pfdec_pkg::SqSize)
  ) u_square_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (filled_q),
    .wr_data_i  (wr_letter),
    .rd_addr_a_i(sq_rd_a),
    .rd_addr_b_i(sq_rd_b),
    .rd_data_a_o(sq_data_a),
    .rd_data_b_o(sq_data_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      filled_q    <= '0;
      ready_q     <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      filled_q    <= filled_d;
      ready_q     <= ready_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_addr_a_q <= sq_addr_a_d;
    sq_addr_b_q <= sq_addr_b_d;
    if (out_load) begin
      plain_first_q  <= sq_data_a;
      plain_second_q <= sq_data_b;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign plain_first_o  = plain_first_q;
  assign plain_second_o = plain_second_q;

endmodule

`default_nettype wire

>>> design/playfair_decrypt_unit.sv
// Playfair decryption unit. A cipher pair passes the back-end states idle, lookup and
// read, set by the two registered lookups (letter to place, then place to letter);
// the back end takes no new request until its pair has left the read state.
// Clear and key letter requests are handled in the idle state; end of key walks
// the alphabet in the fill state. Reset clears the control state and the key;
// the square memories are not cleared and need no clearing pass.
// Uses pfdec_pkg, pfdec_front, pfdec_queue and pfdec_back.
`default_nettype none

module playfair_decrypt_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [pfdec_pkg::LetterW-1:0] letter_first_i,
  input  wire logic [pfdec_pkg::LetterW-1:0] letter_second_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pfdec_pkg::LetterW-1:0]      plain_first_o,
  output logic [pfdec_pkg::LetterW-1:0]      plain_second_o
);

  logic            q_full;
  logic            q_push;
  pfdec_pkg::cmd_t q_cmd;
  logic            q_pop;
  logic            head_valid;
  pfdec_pkg::cmd_t head;

  pfdec_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .letter_first_i (letter_first_i),
    .letter_second_i(letter_second_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (q_cmd)
  );

  pfdec_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .cmd_i       (q_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  pfdec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .plain_first_o (plain_first_o),
    .plain_second_o(plain_second_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_playfair_decrypt_unit.sv
// Self-checking testbench for playfair_decrypt_unit: builds key squares, sends cipher
// pairs and checks every decrypted pair against its own square model, with random
// idling on both channels. Depends on pfdec_pkg and the playfair_decrypt_unit RTL.
`default_nettype none

module tb_playfair_decrypt_unit;
  import pfdec_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomItems = 1350;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
  } plain_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         action_i;
  logic [LetterW-1:0] letter_first_i;
  logic [LetterW-1:0] letter_second_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [LetterW-1:0] plain_first_o;
  logic [LetterW-1:0] plain_second_o;

  logic [LetterW-1:0] sq_letter [SqSize];
  logic [LetterW-1:0] letter_pos [NumLetters];
  logic [NumLetters-1:0] used_mask;
  int                 sq_fill;
  bit                 sq_ready;
  plain_t             plain_due_q [$];

  int errors = 0;
  int requests_sent = 0;
  int pairs_checked = 0;
  int squares_built = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_left = 0;
  logic [15:0] stall_pattern = '0;
  logic [3:0]  stall_phase = '0;

  playfair_decrypt_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .letter_first_i,
    .letter_second_i,
    .out_valid_o,
    .out_stall_i,
    .plain_first_o,
    .plain_second_o
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_playfair_decrypt_unit: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    if (errors <= 30) begin
      $display("cycle %0d: %s: want %0d, got %0d", cycle_count, what, want, got);
    end
  endtask

  function automatic void add_to_square(input logic [LetterW-1:0] v);
    if (sq_fill < SqSize) begin
      sq_letter[sq_fill] = v;
      letter_pos[v] = LetterW'(sq_fill);
      used_mask[v] = 1'b1;
      sq_fill++;
    end
  endfunction

  function automatic void predict_request(input op_e op, input logic [LetterW-1:0] first,
                                          input logic [LetterW-1:0] second);
    logic [LetterW-1:0] a;
    logic [LetterW-1:0] b;
    int v, ra, ca, rb, cb, oa, ob;
    plain_t res;
    a = first;
    b = second;
    case (op)
      OP_CLEAR: begin
        used_mask = '0;
        sq_fill = 0;
        sq_ready = 1'b0;
      end
      OP_KEY: begin
        if (!sq_ready && a < LetterLimit) begin
          if (a == LetterJ) a = LetterI;
          if (!used_mask[a]) add_to_square(a);
        end
      end
      OP_END: begin
        if (!sq_ready) begin
          for (v = 0; v < NumLetters; v++) begin
            if (v != LetterJ && !used_mask[v]) add_to_square(LetterW'(v));
          end
          sq_ready = 1'b1;
          squares_built++;
        end
      end
      default: begin
        if (sq_ready && a < LetterLimit && b < LetterLimit) begin
          if (a == LetterJ) a = LetterI;
          if (b == LetterJ) b = LetterI;
          if (a != b) begin
            ra = letter_pos[a] / SqSide;
            ca = letter_pos[a] % SqSide;
            rb = letter_pos[b] / SqSide;
            cb = letter_pos[b] % SqSide;
            if (ra == rb) begin
              oa = ra * SqSide + (ca + SqSide - 1) % SqSide;
              ob = rb * SqSide + (cb + SqSide - 1) % SqSide;
            end else if (ca == cb) begin
              oa = ((ra + SqSide - 1) % SqSide) * SqSide + ca;
              ob = ((rb + SqSide - 1) % SqSide) * SqSide + cb;
            end else begin
              oa = ra * SqSide + cb;
              ob = rb * SqSide + ca;
            end
            res.first = sq_letter[oa];
            res.second = sq_letter[ob];
            plain_due_q.push_back(res);
          end
        end
      end
    endcase
  endfunction

  function automatic logic [LetterW-1:0] any_code();
    return LetterW'($urandom_range(0, 31));
  endfunction

  function automatic logic [LetterW-1:0] cipher_letter();
    return LetterW'($urandom_range(0, NumLetters - 1));
  endfunction

  task automatic send_request(input op_e op, input logic [LetterW-1:0] first,
                              input logic [LetterW-1:0] second);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    action_i <= op;
    letter_first_i <= first;
    letter_second_i <= second;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(op, first, second);
    requests_sent++;
    burst_left--;
  endtask

  // The receiver stalls on a random 16-bit pattern, now and then a clear one,
  // unless a long hold-off is running.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      if (stall_phase == 4'd0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      end
      out_stall_i <= stall_pattern[stall_phase];
      stall_phase = stall_phase + 4'd1;
    end
  end

  always @(posedge clk_i) begin
    plain_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (plain_due_q.size() == 0) begin
        report_mismatch("result with nothing due", '0,
                        32'({plain_first_o, plain_second_o}));
      end else begin
        want = plain_due_q.pop_front();
        if (plain_first_o !== want.first) begin
          report_mismatch("plain_first", 32'(want.first), 32'(plain_first_o));
        end
        if (plain_second_o !== want.second) begin
          report_mismatch("plain_second", 32'(want.second), 32'(plain_second_o));
        end
        pairs_checked++;
      end
    end
  end

  task automatic test_pair_before_square;
    send_request(OP_PAIR, 5'd0, 5'd25);
    send_request(OP_END, 5'd31, 5'd31);
  endtask

  task automatic test_key_rules;
    send_request(OP_CLEAR, 5'd0, 5'd0);
    send_request(OP_KEY, 5'd25, 5'd0);
    send_request(OP_KEY, LetterJ, 5'd31);
    send_request(OP_KEY, LetterI, 5'd0);
    send_request(OP_KEY, 5'd0, 5'd0);
    send_request(OP_KEY, 5'd0, 5'd0);
    send_request(OP_KEY, 5'd31, 5'd0);
    send_request(OP_KEY, 5'd26, 5'd0);
    send_request(OP_PAIR, 5'd0, 5'd25);
    send_request(OP_END, 5'd0, 5'd0);
    send_request(OP_END, 5'd0, 5'd0);
    send_request(OP_KEY, 5'd2, 5'd0);
  endtask

  task automatic test_pair_cases;
    send_request(OP_PAIR, 5'd25, 5'd2);
    send_request(OP_PAIR, 5'd25, 5'd20);
    send_request(OP_PAIR, 5'd0, 5'd24);
    send_request(OP_PAIR, 5'd5, 5'd5);
    send_request(OP_PAIR, LetterJ, LetterI);
    send_request(OP_PAIR, LetterJ, 5'd25);
    send_request(OP_PAIR, 5'd31, 5'd0);
    send_request(OP_PAIR, 5'd0, 5'd31);
    send_request(OP_PAIR, 5'd26, 5'd3);
  endtask

  task automatic test_empty_key;
    send_request(OP_CLEAR, 5'd31, 5'd31);
    send_request(OP_END, 5'd0, 5'd0);
    send_request(OP_PAIR, 5'd1, 5'd23);
  endtask

  task automatic test_random_sessions;
    int stop_at, key_len, pair_cnt, k;
    stop_at = requests_sent + RandomItems;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 9) != 0) send_request(OP_CLEAR, any_code(), any_code());
      case ($urandom_range(0, 9))
        0: key_len = 0;
        1, 2: key_len = $urandom_range(25, 40);
        default: key_len = $urandom_range(1, 12);
      endcase
      for (k = 0; k < key_len; k++) begin
        send_request(OP_KEY, ($urandom_range(0, 15) == 0) ? LetterW'($urandom_range(26, 31))
                                                          : cipher_letter(), any_code());
      end
      if ($urandom_range(0, 11) == 0) send_request(OP_PAIR, cipher_letter(), cipher_letter());
      if ($urandom_range(0, 15) != 0) send_request(OP_END, any_code(), any_code());
      pair_cnt = $urandom_range(8, 30);
      for (k = 0; k < pair_cnt; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_request(op_e'($urandom_range(0, 3)), any_code(), any_code());
        end else if ($urandom_range(0, 19) == 0) begin
          send_request(OP_PAIR, any_code(), any_code());
        end else begin
          send_request(OP_PAIR, cipher_letter(), cipher_letter());
        end
      end
    end
  endtask

  task automatic test_output_hold;
    int k;
    send_request(OP_CLEAR, 5'd0, 5'd0);
    for (k = 0; k < 6; k++) send_request(OP_KEY, cipher_letter(), 5'd0);
    send_request(OP_END, 5'd0, 5'd0);
    hold_left = HoldCycles;
    for (k = 0; k < 40; k++) send_request(OP_PAIR, cipher_letter(), cipher_letter());
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = OP_CLEAR;
    letter_first_i = '0;
    letter_second_i = '0;
    out_stall_i = 1'b0;
    used_mask = '0;
    sq_fill = 0;
    sq_ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pair_before_square();
    test_key_rules();
    test_pair_cases();
    test_empty_key();
    test_random_sessions();
    test_output_hold();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (plain_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (plain_due_q.size() != 0) begin
      report_mismatch("results never delivered", 32'(plain_due_q.size()), 32'd0);
    end

    $display("sent %0d requests, completed %0d key squares, checked %0d decrypted pairs",
             requests_sent, squares_built, pairs_checked);
    $display("covered key folding and repeats, early and invalid pairs, output hold-off");
    if (errors == 0) begin
      $display("tb_playfair_decrypt_unit: done, clean");
    end else begin
      $display("tb_playfair_decrypt_unit: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/pfdec_pkg.sv
design/pfdec_ram.sv
design/pfdec_front.sv
design/pfdec_queue.sv
design/pfdec_back.sv
design/playfair_decrypt_unit.sv
tb/tb_playfair_decrypt_unit.sv
